// ===== hdl/wire_cut_strip_sequencer_assert.svh =====
// Assertion macros shared by the wire cut-and-strip sequencer RTL.
`ifndef WIRE_CUT_STRIP_SEQUENCER_ASSERT_SVH
`define WIRE_CUT_STRIP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on the clock, off while reset is high.
`define WCSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wcss: same-cycle check failed");

// Next-cycle implication, sampled on the clock, off while reset is high.
`define WCSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wcss: next-cycle check failed");

`endif

// ===== hdl/wcss_pkg.sv =====
// Types, codes and constants shared by the wire cut-and-strip sequencer.
package wcss_pkg;

   // Field widths.
   localparam int MODE_W      = 2;
   localparam int COUNT_IN_W  = 16;
   localparam int WIRE_LEN_W  = 11;
   localparam int STRIP_LEN_W = 9;
   localparam int CORE_W      = 2;
   localparam int QTY_W       = 10;
   localparam int PPM_W       = 16;
   localparam int PULSE_W     = 16;
   localparam int ACTION_W    = 3;
   localparam int PHASE_W     = 3;
   localparam int FIN_W       = 10;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Defaults for the top-level parameters.
   localparam int ENCODER_CENTER_DEFAULT = 32000;
   localparam int COUNT_WIDTH_DEFAULT    = 10;

   // Signed compare width; holds every threshold for centers up to 60000.
   localparam int THR_W = 19;

   // Motion constants in encoder pulses.
   localparam int BACK_PULSES = 100;
   localparam int EJECT_EXTRA = 600;
   localparam int CORE_OFFSET = 1500;
   localparam int OFFSET_W    = 13;

   // Q8 conversion.
   localparam int Q8_FRAC    = 8;
   localparam int ROUND_HALF = 128;

   // Register reset values.
   localparam logic [WIRE_LEN_W-1:0]  WIRE_LEN_RST   = WIRE_LEN_W'(200);
   localparam logic [STRIP_LEN_W-1:0] STRIP_LEN_RST  = STRIP_LEN_W'(10);
   localparam logic [CORE_W-1:0]      CORE_RST       = CORE_W'(1);
   localparam logic [QTY_W-1:0]       QTY_RST        = QTY_W'(1);
   localparam logic [PPM_W-1:0]       PPM_RST        = PPM_W'(7314);
   localparam logic [PULSE_W-1:0]     BLADE_HOME_RST = PULSE_W'(4000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WIRE_LENGTH  = 3'd0,
      REG_STRIP_LENGTH = 3'd1,
      REG_CORE_SIZE    = 3'd2,
      REG_BATCH_QTY    = 3'd3,
      REG_PULSES_PER_MM = 3'd4,
      REG_BLADE_HOME   = 3'd5
   } reg_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK      = 2'd0,
      MODE_START     = 2'd1,
      MODE_STOP      = 2'd2,
      MODE_BLADE_SET = 2'd3
   } mode_type;

   typedef enum logic [ACTION_W-1:0] {
      BLADE_NONE  = 3'd0,
      BLADE_LOWER = 3'd1,
      BLADE_RAISE = 3'd2,
      BLADE_CUT   = 3'd3,
      BLADE_SET   = 3'd4
   } blade_action_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_STRIP_HEAD = 3'd0,
      PH_BACK_HEAD  = 3'd1,
      PH_FEED       = 3'd2,
      PH_BACK_TAIL  = 3'd3,
      PH_STRIP_TAIL = 3'd4,
      PH_EJECT      = 3'd5
   } phase_type;

   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic [COUNT_IN_W-1:0] feed_count;
      logic [COUNT_IN_W-1:0] eject_count;
   } req_type;

   typedef struct packed {
      logic                motor1_run;
      logic                motor1_reverse;
      logic                motor2_run;
      logic                motor2_reverse;
      logic                reset_feed_encoder;
      logic                reset_eject_encoder;
      logic [ACTION_W-1:0] blade_action;
      logic [PULSE_W-1:0]  blade_distance;
      logic [PHASE_W-1:0]  current_phase;
      logic [FIN_W-1:0]    finished_count;
      logic                machine_running;
      logic                status;
   } rsp_type;

   // Settings and derived targets handed from the register block to the core.
   typedef struct packed {
      logic [QTY_W-1:0]   batch_quantity;
      logic [PULSE_W-1:0] wire_pulses;
      logic [PULSE_W-1:0] strip_pulses;
      logic [PULSE_W-1:0] blade_distance;
   } cfg_type;

endpackage

// ===== hdl/wcss_config.sv =====
// Configuration registers and the pulse targets derived from them.
module wcss_config
   import wcss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   localparam int WIRE_PROD_W  = WIRE_LEN_W + PPM_W;
   localparam int STRIP_PROD_W = STRIP_LEN_W + PPM_W;

   logic [WIRE_LEN_W-1:0]  wire_len_ff;
   logic [STRIP_LEN_W-1:0] strip_len_ff;
   logic [CORE_W-1:0]      core_ff;
   logic [QTY_W-1:0]       qty_ff;
   logic [PPM_W-1:0]       ppm_ff;
   logic [PULSE_W-1:0]     home_ff;

   logic [WIRE_PROD_W:0]   wire_round;
   logic [STRIP_PROD_W:0]  strip_round;
   logic [WIRE_PROD_W-Q8_FRAC:0]  wire_q;
   logic [STRIP_PROD_W-Q8_FRAC:0] strip_q;
   logic [OFFSET_W-1:0]    offset;

   logic [PULSE_W-1:0]     wire_pulses_ff,  wire_pulses_in;
   logic [PULSE_W-1:0]     strip_pulses_ff, strip_pulses_in;
   logic [PULSE_W-1:0]     distance_ff,     distance_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wire_len_ff  <= WIRE_LEN_RST;
         strip_len_ff <= STRIP_LEN_RST;
         core_ff      <= CORE_RST;
         qty_ff       <= QTY_RST;
         ppm_ff       <= PPM_RST;
         home_ff      <= BLADE_HOME_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WIRE_LENGTH:   wire_len_ff  <= csr_wdata[WIRE_LEN_W-1:0];
            REG_STRIP_LENGTH:  strip_len_ff <= csr_wdata[STRIP_LEN_W-1:0];
            REG_CORE_SIZE:     core_ff      <= csr_wdata[CORE_W-1:0];
            REG_BATCH_QTY:     qty_ff       <= csr_wdata[QTY_W-1:0];
            REG_PULSES_PER_MM: ppm_ff       <= csr_wdata[PPM_W-1:0];
            REG_BLADE_HOME:    home_ff      <= csr_wdata[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // Millimetres to pulses: round half up on the Q8 product, then clamp to 16 bits.
   always_comb begin
      wire_round  = (WIRE_PROD_W+1)'(wire_len_ff * ppm_ff) + (WIRE_PROD_W+1)'(ROUND_HALF);
      strip_round = (STRIP_PROD_W+1)'(strip_len_ff * ppm_ff)
                    + (STRIP_PROD_W+1)'(ROUND_HALF);
      wire_q  = wire_round[WIRE_PROD_W:Q8_FRAC];
      strip_q = strip_round[STRIP_PROD_W:Q8_FRAC];
      wire_pulses_in  = (|wire_q[WIRE_PROD_W-Q8_FRAC:PULSE_W]) ? '1 : wire_q[PULSE_W-1:0];
      strip_pulses_in = (|strip_q[STRIP_PROD_W-Q8_FRAC:PULSE_W]) ? '1 : strip_q[PULSE_W-1:0];

      offset      = OFFSET_W'(core_ff * OFFSET_W'(CORE_OFFSET));
      distance_in = (home_ff > PULSE_W'(offset)) ? home_ff - PULSE_W'(offset) : '0;
   end

   always_ff @(posedge clock) begin
      wire_pulses_ff  <= wire_pulses_in;
      strip_pulses_ff <= strip_pulses_in;
      distance_ff     <= distance_in;
   end

   assign cfg.batch_quantity = qty_ff;
   assign cfg.wire_pulses    = wire_pulses_ff;
   assign cfg.strip_pulses   = strip_pulses_ff;
   assign cfg.blade_distance = distance_ff;

endmodule

// ===== hdl/wire_cut_strip_sequencer.sv =====
// Top level of the wire cut-and-strip motion sequencer.
// The sequencer takes one transaction per clock on the req_ channel and returns exactly one
// result transaction per request on the rsp_ channel, in order. A request passes through an
// input register, is decoded and compared against the phase thresholds combinationally,
// and lands in the output register, so a result is offered once its request has passed both
// registers; a new request can be taken in every cycle while the rsp_ side keeps up. Holding
// rsp_stall makes the output register hold, and the input register then raises req_stall
// in the same cycle. The six settings are written through the csr_ port, which is always
// ready; write them only while no request is in flight. Pulse targets derived from them are
// registered once, so a request taken on the cycle after a write already sees the new value.
// Phases 0 to 4 strip the head, back off, feed the wire, back off and strip the tail, and
// run only while the machine is on and the blade has been set; phase 5 ejects the last wire
// of a batch with motor 2 whether or not the machine is on.
`include "wire_cut_strip_sequencer_assert.svh"

module wire_cut_strip_sequencer
   import wcss_pkg::*;
#(
   parameter int ENCODER_CENTER = ENCODER_CENTER_DEFAULT,
   parameter int COUNT_WIDTH    = COUNT_WIDTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The finished count is compared against the batch quantity at the wider of the two.
   localparam int CMP_W = (COUNT_WIDTH > QTY_W) ? COUNT_WIDTH : QTY_W;
   localparam logic signed [THR_W-1:0] CENTER_S = THR_W'(ENCODER_CENTER);
   localparam logic signed [THR_W-1:0] BACK_S   = THR_W'(BACK_PULSES);
   localparam logic signed [THR_W-1:0] EJECT_S  = THR_W'(EJECT_EXTRA);

   cfg_type cfg;

   // Pipeline control.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    accept_in, out_free, fire;

   // Sequencer state.
   phase_type              phase_ff, phase_in;
   logic                   running_ff, running_in;
   logic                   blade_cal_ff, blade_cal_in;
   logic                   batch_open_ff, batch_open_in;
   logic [COUNT_WIDTH-1:0] done_ff, done_in, done_inc;

   // Threshold datapath.
   logic signed [THR_W-1:0] feed_s, eject_s, wire_s, strip_s;
   logic signed [THR_W-1:0] thr_head, thr_back, thr_feed, thr_tail, thr_eject;
   logic                    hit;
   logic                    batch_done;

   wcss_config u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The output register moves whenever it is empty or being taken; the input register
   // stalls only when it holds a transaction that cannot move forward.
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign accept_in   = req_valid && !req_stall;
   assign in_valid_in = accept_in || (in_valid_ff && !out_free);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Encoder samples are unsigned; all thresholds are compared as signed, so a threshold below
   // zero always passes a >= test but never a <= test; one above the sample range, the reverse.
   always_comb begin
      feed_s   = $signed({{(THR_W-COUNT_IN_W){1'b0}}, in_data_ff.feed_count});
      eject_s  = $signed({{(THR_W-COUNT_IN_W){1'b0}}, in_data_ff.eject_count});
      wire_s   = $signed({{(THR_W-PULSE_W){1'b0}}, cfg.wire_pulses});
      strip_s  = $signed({{(THR_W-PULSE_W){1'b0}}, cfg.strip_pulses});
      thr_head  = CENTER_S + strip_s;
      thr_back  = CENTER_S - BACK_S;
      thr_feed  = CENTER_S + BACK_S + wire_s - (strip_s <<< 1);
      thr_tail  = CENTER_S + strip_s - BACK_S;
      thr_eject = CENTER_S + wire_s + EJECT_S;
   end

   // Threshold test for a tick. The eject phase runs even while the machine is off; the
   // other phases only move while the machine is on and the blade is set.
   always_comb begin
      hit = 1'b0;
      if (in_data_ff.mode == MODE_TICK) begin
         unique case (phase_ff) inside
            PH_STRIP_HEAD:              hit = running_ff && blade_cal_ff && (feed_s >= thr_head);
            PH_BACK_HEAD, PH_BACK_TAIL: hit = running_ff && blade_cal_ff && (feed_s <= thr_back);
            PH_FEED:                    hit = running_ff && blade_cal_ff && (feed_s >= thr_feed);
            PH_STRIP_TAIL:              hit = running_ff && blade_cal_ff && (feed_s >= thr_tail);
            PH_EJECT:                   hit = (eject_s >= thr_eject);
            default:                    hit = 1'b0;
         endcase
      end
   end

   // A quantity of zero never closes the batch.
   assign done_inc   = done_ff + COUNT_WIDTH'(1);
   assign batch_done = (cfg.batch_quantity != '0)
                       && (CMP_W'(done_inc) == CMP_W'(cfg.batch_quantity));

   // Next-state logic.
   always_comb begin
      phase_in      = phase_ff;
      running_in    = running_ff;
      blade_cal_in  = blade_cal_ff;
      batch_open_in = batch_open_ff;
      done_in       = done_ff;
      unique case (in_data_ff.mode)
         MODE_START: begin
            if (blade_cal_ff) begin
               running_in = 1'b1;
               if (!batch_open_ff) begin
                  done_in       = '0;
                  batch_open_in = 1'b1;
               end
            end
         end
         MODE_STOP: begin
            running_in = 1'b0;
         end
         MODE_BLADE_SET: begin
            if (!running_ff && !blade_cal_ff) begin
               blade_cal_in = 1'b1;
            end
         end
         default: begin
            if (hit) begin
               unique case (phase_ff)
                  PH_STRIP_HEAD: phase_in = PH_BACK_HEAD;
                  PH_BACK_HEAD:  phase_in = PH_FEED;
                  PH_FEED:       phase_in = PH_BACK_TAIL;
                  PH_BACK_TAIL:  phase_in = PH_STRIP_TAIL;
                  PH_STRIP_TAIL: begin
                     done_in = done_inc;
                     if (batch_done) begin
                        running_in    = 1'b0;
                        batch_open_in = 1'b0;
                        phase_in      = PH_EJECT;
                     end else begin
                        phase_in = PH_STRIP_HEAD;
                     end
                  end
                  default: phase_in = PH_STRIP_HEAD;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_STRIP_HEAD;
         running_ff    <= 1'b0;
         blade_cal_ff  <= 1'b0;
         batch_open_ff <= 1'b0;
         done_ff       <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         running_ff    <= running_in;
         blade_cal_ff  <= blade_cal_in;
         batch_open_ff <= batch_open_in;
         done_ff       <= done_in;
      end
   end

   // Result logic. A step that meets its threshold reports the motors stopped; otherwise
   // the drive levels follow the phase and run flag after the step.
   always_comb begin
      logic [CMP_W-1:0] done_ext;
      rsp_data_in = '0;
      done_ext    = CMP_W'(done_in);

      if (in_data_ff.mode == MODE_START && !blade_cal_ff) begin
         rsp_data_in.status = 1'b1;
      end
      if (in_data_ff.mode == MODE_BLADE_SET && !running_ff && !blade_cal_ff) begin
         rsp_data_in.blade_action = BLADE_SET;
      end

      if (hit) begin
         rsp_data_in.reset_eject_encoder = 1'b1;
         rsp_data_in.reset_feed_encoder  = (phase_ff != PH_EJECT);
         unique case (phase_ff) inside
            PH_STRIP_HEAD, PH_FEED: begin
               rsp_data_in.blade_action   = BLADE_LOWER;
               rsp_data_in.blade_distance = cfg.blade_distance;
            end
            PH_BACK_HEAD, PH_BACK_TAIL: begin
               rsp_data_in.blade_action   = BLADE_RAISE;
               rsp_data_in.blade_distance = cfg.blade_distance;
            end
            PH_STRIP_TAIL: rsp_data_in.blade_action = BLADE_CUT;
            default: ;
         endcase
      end else begin
         unique case (phase_in) inside
            PH_EJECT: rsp_data_in.motor2_run = 1'b1;
            PH_STRIP_HEAD, PH_FEED, PH_STRIP_TAIL: begin
               rsp_data_in.motor1_run = running_in;
               rsp_data_in.motor2_run = running_in;
            end
            PH_BACK_HEAD, PH_BACK_TAIL: begin
               rsp_data_in.motor1_run     = running_in;
               rsp_data_in.motor2_run     = running_in;
               rsp_data_in.motor1_reverse = running_in;
               rsp_data_in.motor2_reverse = running_in;
            end
            default: ;
         endcase
      end

      rsp_data_in.current_phase   = phase_in;
      rsp_data_in.finished_count  = done_ext[FIN_W-1:0];
      rsp_data_in.machine_running = running_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The machine only runs once the blade is set, and only inside an open batch.
   `WCSS_ASSERT_NOW(a_run_needs_blade, running_ff, blade_cal_ff)
   `WCSS_ASSERT_NOW(a_run_needs_batch, running_ff, batch_open_ff)
   // A cut always comes with an encoder reload and stopped motors.
   `WCSS_ASSERT_NOW(a_cut_reloads, rsp_valid_ff && rsp_data_ff.blade_action == BLADE_CUT,
      rsp_data_ff.reset_feed_encoder && !rsp_data_ff.motor1_run)
   // Every accepted transaction is held in the input register on the next cycle.
   `WCSS_ASSERT_NEXT(a_accept_lands, req_valid && !req_stall, in_valid_ff)

endmodule
